FILE: rtl/core/crte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crte_pkg
// Shared types, constants and helper functions of the cartridge ROM transfer
// engine.
// ----------------------------------------------------------------------------
package crte_pkg;

  localparam int ADDR_BITS   = 29;
  localparam int OFFSET_W    = 12;
  localparam int COUNT_W     = 15;
  localparam int ROM_SIZE_W  = 30;
  localparam int CHIP_ID_W   = 32;
  localparam int CMD_W       = 64;
  localparam int CODE_W      = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  localparam int IN_DATA_W   = ((CMD_W + CODE_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_DATA_W - CMD_W - CODE_W;
  localparam int OUT_FIELD_W = ADDR_BITS + 12;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

  localparam logic [7:0]  CMD_READ_DATA = 8'hb7;
  localparam logic [7:0]  CMD_READ_ID   = 8'hb8;
  localparam logic [31:0] PAGE_MASK     = 32'hfffff000;
  localparam logic [ADDR_BITS-1:0] BASE_LIFT = ADDR_BITS'(32'h8000);
  localparam logic [7:0]  FILL_BYTE     = 8'hff;
  localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_RST = ROM_SIZE_W'(65536);

  localparam logic [CFG_INDEX_W-1:0] REG_CARD_PRESENT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROM_SIZE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHIP_ID      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IRQ_ENABLE   = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_DATA = 2'd1,
    MODE_ID   = 2'd2
  } card_mode_t;

  typedef struct packed {
    logic                  card_present;
    logic [ROM_SIZE_W-1:0] rom_size;
    logic [CHIP_ID_W-1:0]  chip_id;
    logic                  irq_enable;
  } cfg_t;

  typedef struct packed {
    card_mode_t            mode;
    logic [OFFSET_W-1:0]   read_offset;
    logic [ADDR_BITS-1:0]  block_base;
    logic [COUNT_W-1:0]    bytes_left;
    logic                  ready;
    logic                  pending;
  } state_t;

  typedef struct packed {
    logic                 rom_fetch;
    logic [ADDR_BITS-1:0] rom_addr;
    logic [7:0]           fixed_byte;
    logic                 busy_res;
    logic                 data_ready;
    logic                 transfer_done;
    logic                 irq;
  } result_t;

  // Transfer length in bytes for a block-size code.
  function automatic logic [COUNT_W-1:0] block_len(input logic [CODE_W-1:0] code);
    logic [COUNT_W-1:0] len;
    len = '0;
    case (code)
      3'd0:    len = '0;
      3'd7:    len = COUNT_W'(4);
      default: len = COUNT_W'(512) << (code - 3'd1);
    endcase
    return len;
  endfunction

  // Card size minus one: rom_size rounded up to a power of two, capped.
  function automatic logic [ADDR_BITS-1:0] card_mask(input logic [ROM_SIZE_W-1:0] size);
    logic [ROM_SIZE_W-1:0] v;
    logic [ADDR_BITS-1:0]  m;
    v = size - ROM_SIZE_W'(1);
    v = v | (v >> 1);
    v = v | (v >> 2);
    v = v | (v >> 4);
    v = v | (v >> 8);
    v = v | (v >> 16);
    if (size <= ROM_SIZE_W'(1)) begin
      m = '0;
    end else if (ADDR_BITS >= ROM_SIZE_W) begin
      m = ADDR_BITS'(v);
    end else begin
      m = ADDR_BITS'(v & ROM_SIZE_W'({ADDR_BITS{1'b1}}));
    end
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/crte_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crte_step
// Next-state and result logic for one item: start decode, address window,
// ID byte select and byte countdown.
// ----------------------------------------------------------------------------
module crte_step (
  input  wire crte_pkg::cfg_t                     cfg,
  input  wire crte_pkg::state_t                   cur,
  input  wire logic                               action,
  input  wire logic [crte_pkg::CMD_W-1:0]         card_command,
  input  wire logic [crte_pkg::CODE_W-1:0]        block_size,
  output crte_pkg::state_t                        nxt,
  output crte_pkg::result_t                       res
);

  logic [crte_pkg::ADDR_BITS-1:0]  mask;
  logic [crte_pkg::COUNT_W-1:0]    len;
  logic [7:0]                      top;
  logic [31:0]                     mid;
  logic [crte_pkg::ADDR_BITS-1:0]  base_m;
  logic [crte_pkg::ADDR_BITS-1:0]  addr;
  logic [crte_pkg::COUNT_W-1:0]    left_dec;
  logic [7:0]                      id_byte;

  always_comb begin
    mask     = crte_pkg::card_mask(cfg.rom_size);
    len      = crte_pkg::block_len(block_size);
    top      = card_command[63:56];
    mid      = card_command[55:24];
    base_m   = crte_pkg::ADDR_BITS'(mid & crte_pkg::PAGE_MASK) & mask;
    addr     = (cur.block_base + crte_pkg::ADDR_BITS'(cur.read_offset)) & mask;
    left_dec = cur.bytes_left - crte_pkg::COUNT_W'(1);
    case (cur.read_offset[1:0])
      2'd0:    id_byte = cfg.chip_id[7:0];
      2'd1:    id_byte = cfg.chip_id[15:8];
      2'd2:    id_byte = cfg.chip_id[23:16];
      default: id_byte = cfg.chip_id[31:24];
    endcase

    nxt               = cur;
    res.rom_fetch     = 1'b0;
    res.rom_addr      = '0;
    res.fixed_byte    = '0;
    res.transfer_done = 1'b0;
    res.irq           = 1'b0;

    if (!action) begin
      nxt.bytes_left = len;
      nxt.pending    = (len != '0);
      if (len != '0) begin
        nxt.ready = 1'b1;
      end
      if (cfg.card_present) begin
        if (top == crte_pkg::CMD_READ_DATA) begin
          nxt.mode        = crte_pkg::MODE_DATA;
          nxt.read_offset = mid[crte_pkg::OFFSET_W-1:0];
          if (base_m < crte_pkg::BASE_LIFT) begin
            nxt.block_base = base_m + crte_pkg::BASE_LIFT;
          end else begin
            nxt.block_base = base_m;
          end
        end else if (top == crte_pkg::CMD_READ_ID) begin
          nxt.mode        = crte_pkg::MODE_ID;
          nxt.read_offset = '0;
        end
      end
    end else begin
      res.fixed_byte = crte_pkg::FILL_BYTE;
      if (cur.bytes_left != '0) begin
        if (cfg.card_present) begin
          if (cur.mode == crte_pkg::MODE_DATA) begin
            nxt.read_offset = cur.read_offset + crte_pkg::OFFSET_W'(1);
            if (33'(addr) < 33'(cfg.rom_size)) begin
              res.rom_fetch  = 1'b1;
              res.rom_addr   = addr;
              res.fixed_byte = '0;
            end
          end else if (cur.mode == crte_pkg::MODE_ID) begin
            res.fixed_byte  = id_byte;
            nxt.read_offset = {{(crte_pkg::OFFSET_W-2){1'b0}},
                               cur.read_offset[1:0] + 2'd1};
          end
        end
        nxt.bytes_left = left_dec;
        if (left_dec == '0) begin
          nxt.ready         = 1'b0;
          nxt.pending       = 1'b0;
          res.transfer_done = 1'b1;
          res.irq           = cfg.irq_enable;
        end
      end
    end

    res.busy_res   = nxt.pending;
    res.data_ready = nxt.ready;
  end

endmodule
`default_nettype wire

FILE: rtl/core/card_rom_transfer_engine.sv
// Each accepted item's result is registered, then shown on out_tdata.
// Throughput: one item per cycle while in_tready is high; the step logic
// is combinational, state_r updates per accepted item. A two-entry output
// buffer drops in_tready only once two results wait on a stalled output.
// Reset: synchronous, active-low rst_n clears the transfer state, the output
// buffer and sets the registers to card absent, 64 KiB image, ID 0, no IRQ.
`default_nettype none
// ----------------------------------------------------------------------------
// card_rom_transfer_engine
// Cartridge ROM transfer engine: start items load a card command, read items
// yield one byte each as a ROM fetch address or a fixed byte.
// ----------------------------------------------------------------------------
module card_rom_transfer_engine (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [crte_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [crte_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // card_command [63:0], block_size [66:64], zero fill above.
  input  wire logic [crte_pkg::IN_DATA_W-1:0]       in_tdata,
  // action [0].
  input  wire logic                                 in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // rom_addr [28:0], fixed_byte [36:29], busy_res [37], data_ready [38],
  // transfer_done [39], irq [40], zero fill above.
  output logic [crte_pkg::OUT_DATA_W-1:0]           out_tdata,
  // rom_fetch [0].
  output logic                                      out_tuser
);

  crte_pkg::cfg_t    cfg_r;
  crte_pkg::state_t  state_r;
  crte_pkg::state_t  state_nxt;
  crte_pkg::result_t step_res;
  crte_pkg::result_t out_r;
  crte_pkg::result_t skid_r;
  logic              out_valid_r;
  logic              skid_valid_r;
  logic              in_acc;
  logic              out_pop;

  crte_step u_step (
    .cfg          (cfg_r),
    .cur          (state_r),
    .action       (in_tuser),
    .card_command (in_tdata[crte_pkg::CMD_W-1:0]),
    .block_size   (in_tdata[crte_pkg::CMD_W +: crte_pkg::CODE_W]),
    .nxt          (state_nxt),
    .res          (step_res)
  );

  assign in_tready  = !skid_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_pop    = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.rom_fetch;
  assign out_tdata  = {{crte_pkg::OUT_PAD_W{1'b0}}, out_r.irq, out_r.transfer_done,
                       out_r.data_ready, out_r.busy_res, out_r.fixed_byte,
                       out_r.rom_addr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.card_present <= 1'b0;
      cfg_r.rom_size     <= crte_pkg::ROM_SIZE_RST;
      cfg_r.chip_id      <= '0;
      cfg_r.irq_enable   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crte_pkg::REG_CARD_PRESENT: cfg_r.card_present <= cfg_wdata[0];
        crte_pkg::REG_ROM_SIZE:
          cfg_r.rom_size <= cfg_wdata[crte_pkg::ROM_SIZE_W-1:0];
        crte_pkg::REG_CHIP_ID:      cfg_r.chip_id <= cfg_wdata;
        crte_pkg::REG_IRQ_ENABLE:   cfg_r.irq_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode        <= crte_pkg::MODE_IDLE;
      state_r.read_offset <= '0;
      state_r.block_base  <= '0;
      state_r.bytes_left  <= '0;
      state_r.ready       <= 1'b0;
      state_r.pending     <= 1'b0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_pop) begin
        out_r       <= step_res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= step_res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");

  a_pending_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pending == (state_r.bytes_left != '0))
    else $error("pending flag disagrees with remaining byte count");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.transfer_done) |-> (!out_r.busy_res && !out_r.data_ready))
    else $error("finished transfer still reports busy or ready");

  a_fetch_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.rom_fetch) |-> (out_r.fixed_byte == '0))
    else $error("ROM fetch item carries a fixed byte");
`endif

endmodule
`default_nettype wire

FILE: test/card_rom_transfer_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// card_rom_transfer_engine_tb
// Self-checking bench for the cartridge ROM transfer engine. Start and read
// items go in on the input stream, and an item-level predictor works out the
// byte, address and flags of every item. Results are checked in order against
// the prediction under random idling on both sides, a long output stall and
// several register settings.
// ----------------------------------------------------------------------------
module card_rom_transfer_engine_tb;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic [crte_pkg::CODE_W-1:0] CODE_NONE = 3'd0;
  localparam logic [crte_pkg::CODE_W-1:0] CODE_512  = 3'd1;
  localparam logic [crte_pkg::CODE_W-1:0] CODE_16K  = 3'd6;
  localparam logic [crte_pkg::CODE_W-1:0] CODE_FOUR = 3'd7;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 64;

  class transfer_checker;
    logic                            card_present;
    logic [crte_pkg::ROM_SIZE_W-1:0] rom_size;
    logic [crte_pkg::CHIP_ID_W-1:0]  chip_id;
    logic                            irq_enable;
    crte_pkg::card_mode_t            mode;
    logic [crte_pkg::OFFSET_W-1:0]   offset;
    logic [crte_pkg::ADDR_BITS-1:0]  base;
    logic [crte_pkg::COUNT_W-1:0]    left;
    logic                            ready;
    logic                            busy;
    crte_pkg::result_t               expected_bytes[$];
    int                              errors;
    int                              checked;
    int                              finished;
    int                              fetched;

    function new();
      card_present = 1'b0;
      rom_size     = crte_pkg::ROM_SIZE_W'(65536);
      chip_id      = '0;
      irq_enable   = 1'b0;
      mode         = crte_pkg::MODE_IDLE;
      offset       = '0;
      base         = '0;
      left         = '0;
      ready        = 1'b0;
      busy         = 1'b0;
      errors       = 0;
      checked      = 0;
      finished     = 0;
      fetched      = 0;
    endfunction

    function void write_reg(logic [crte_pkg::CFG_INDEX_W-1:0] idx,
                            logic [crte_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        crte_pkg::REG_CARD_PRESENT: card_present = val[0];
        crte_pkg::REG_ROM_SIZE:     rom_size = val[crte_pkg::ROM_SIZE_W-1:0];
        crte_pkg::REG_CHIP_ID:      chip_id = val;
        crte_pkg::REG_IRQ_ENABLE:   irq_enable = val[0];
        default: ;
      endcase
    endfunction

    // Card size minus one, with the size a power of two no larger than the
    // address space.
    function logic [crte_pkg::ROM_SIZE_W-1:0] size_mask();
      logic [crte_pkg::ROM_SIZE_W:0] p;
      p = 1;
      while (p < rom_size &&
             p < ((crte_pkg::ROM_SIZE_W+1)'(1) << crte_pkg::ADDR_BITS))
        p = p << 1;
      return crte_pkg::ROM_SIZE_W'(p - 1);
    endfunction

    function void take_item(logic act, logic [crte_pkg::CMD_W-1:0] cmd,
                            logic [crte_pkg::CODE_W-1:0] code);
      crte_pkg::result_t               r;
      logic [crte_pkg::COUNT_W-1:0]    len;
      logic [31:0]                     mid;
      logic [crte_pkg::ROM_SIZE_W-1:0] a;
      r = '0;
      if (act == ACT_START) begin
        if (code == CODE_NONE)
          len = '0;
        else if (code == CODE_FOUR)
          len = crte_pkg::COUNT_W'(4);
        else
          len = crte_pkg::COUNT_W'(256) << code;
        busy = 1'b1;
        left = len;
        if (len != 0)
          ready = 1'b1;
        else
          busy = 1'b0;
        if (card_present) begin
          if (cmd[63:56] == crte_pkg::CMD_READ_DATA) begin
            mid    = cmd[55:24];
            mode   = crte_pkg::MODE_DATA;
            offset = mid[crte_pkg::OFFSET_W-1:0];
            base   = crte_pkg::ADDR_BITS'((mid & crte_pkg::PAGE_MASK) &
                                          32'(size_mask()));
            if (base < crte_pkg::ADDR_BITS'(32'h8000))
              base = base + crte_pkg::ADDR_BITS'(32'h8000);
          end else if (cmd[63:56] == crte_pkg::CMD_READ_ID) begin
            mode   = crte_pkg::MODE_ID;
            offset = '0;
          end
        end
      end else begin
        r.fixed_byte = crte_pkg::FILL_BYTE;
        if (left != 0) begin
          if (card_present && mode == crte_pkg::MODE_DATA) begin
            a = (crte_pkg::ROM_SIZE_W'(base) + crte_pkg::ROM_SIZE_W'(offset)) &
                size_mask();
            offset = offset + 1'b1;
            if (a < rom_size) begin
              r.rom_fetch  = 1'b1;
              r.rom_addr   = a[crte_pkg::ADDR_BITS-1:0];
              r.fixed_byte = '0;
            end
          end else if (card_present && mode == crte_pkg::MODE_ID) begin
            r.fixed_byte = chip_id[8*offset[1:0] +: 8];
            offset = {{(crte_pkg::OFFSET_W-2){1'b0}}, offset[1:0] + 2'd1};
          end
          left = left - 1'b1;
          if (left == 0) begin
            ready           = 1'b0;
            busy            = 1'b0;
            r.transfer_done = 1'b1;
            r.irq           = irq_enable;
          end
        end
      end
      r.busy_res   = busy;
      r.data_ready = ready;
      expected_bytes.push_back(r);
    endfunction

    function void check_byte(crte_pkg::result_t got);
      crte_pkg::result_t exp;
      string             bad;
      checked++;
      if (got.transfer_done) finished++;
      if (got.rom_fetch) fetched++;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result with nothing expected: fetch=%0b addr=%h byte=%h",
                   got.rom_fetch, got.rom_addr, got.fixed_byte);
        return;
      end
      exp = expected_bytes.pop_front();
      bad = "";
      if (got.rom_fetch !== exp.rom_fetch) bad = {bad, " rom_fetch"};
      if (got.rom_addr !== exp.rom_addr) bad = {bad, " rom_addr"};
      if (got.fixed_byte !== exp.fixed_byte) bad = {bad, " fixed_byte"};
      if (got.busy_res !== exp.busy_res) bad = {bad, " busy_res"};
      if (got.data_ready !== exp.data_ready) bad = {bad, " data_ready"};
      if (got.transfer_done !== exp.transfer_done) bad = {bad, " transfer_done"};
      if (got.irq !== exp.irq) bad = {bad, " irq"};
      if (bad != "") begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result %0d differs in%s", checked, bad);
          $display("  expected fetch=%0b addr=%h byte=%h busy=%0b ready=%0b done=%0b irq=%0b",
                   exp.rom_fetch, exp.rom_addr, exp.fixed_byte, exp.busy_res,
                   exp.data_ready, exp.transfer_done, exp.irq);
          $display("  actual   fetch=%0b addr=%h byte=%h busy=%0b ready=%0b done=%0b irq=%0b",
                   got.rom_fetch, got.rom_addr, got.fixed_byte, got.busy_res,
                   got.data_ready, got.transfer_done, got.irq);
        end
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [crte_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [crte_pkg::CFG_DATA_W-1:0]  cfg_wdata;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [crte_pkg::IN_DATA_W-1:0]   in_tdata;
  logic                             in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [crte_pkg::OUT_DATA_W-1:0]  out_tdata;
  logic                             out_tuser;

  transfer_checker sb = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int sent = 0;
  int quiet = 0;

  card_rom_transfer_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    crte_pkg::result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.take_item(in_tuser, in_tdata[crte_pkg::CMD_W-1:0],
                     in_tdata[crte_pkg::CMD_W+crte_pkg::CODE_W-1:crte_pkg::CMD_W]);
      if (out_tvalid && out_tready) begin
        got.rom_fetch     = out_tuser;
        got.rom_addr      = out_tdata[28:0];
        got.fixed_byte    = out_tdata[36:29];
        got.busy_res      = out_tdata[37];
        got.data_ready    = out_tdata[38];
        got.transfer_done = out_tdata[39];
        got.irq           = out_tdata[40];
        sb.check_byte(got);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("card_rom_transfer_engine_tb failed");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= (!idle_on || $urandom_range(99) >= 36);
    end
  end

  task automatic send_item(input logic act, input logic [crte_pkg::CMD_W-1:0] cmd,
                           input logic [crte_pkg::CODE_W-1:0] code);
    while (idle_on && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      in_tdata  <= crte_pkg::IN_DATA_W'({$urandom, $urandom, $urandom});
      in_tuser  <= 1'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{crte_pkg::IN_PAD_W{1'b0}}, code, cmd};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [crte_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [crte_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_settings(input logic cp,
                                input logic [crte_pkg::ROM_SIZE_W-1:0] rs,
                                input logic [crte_pkg::CHIP_ID_W-1:0] id,
                                input logic ie);
    put_reg(crte_pkg::REG_CARD_PRESENT, {31'($urandom), cp});
    put_reg(crte_pkg::REG_ROM_SIZE, {2'($urandom), rs});
    put_reg(crte_pkg::REG_CHIP_ID, id);
    put_reg(crte_pkg::REG_IRQ_ENABLE, {31'($urandom), ie});
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed transfers: a start followed by reads, with a few
  // extra reads after the end and some stray items in between.
  task automatic random_phase(input int n);
    int                          first;
    int                          reads;
    logic [7:0]                  top;
    logic [31:0]                 mid;
    logic [crte_pkg::CODE_W-1:0] code;
    first = sent;
    while (sent - first < n) begin
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(3))
          0, 1:    top = crte_pkg::CMD_READ_DATA;
          2:       top = crte_pkg::CMD_READ_ID;
          default: top = 8'($urandom);
        endcase
        mid = $urandom;
        if ($urandom_range(3) == 0)
          mid[11:0] = 12'hff8 | 12'($urandom_range(7));
        code = ($urandom_range(9) < 7) ? CODE_FOUR : 3'($urandom_range(6));
        send_item(ACT_START, {top, mid, 24'($urandom)}, code);
        reads = (code == CODE_FOUR) ? 4 + $urandom_range(2) : $urandom_range(1, 6);
        repeat (reads) send_item(ACT_READ, {$urandom, $urandom}, 3'($urandom));
      end else begin
        send_item(1'($urandom), {$urandom, $urandom}, 3'($urandom));
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty slot: the command is ignored and reads return the fill byte.
    send_item(ACT_START, {crte_pkg::CMD_READ_DATA, 56'h0}, CODE_FOUR);
    send_item(ACT_READ, '0, CODE_NONE);
    send_item(ACT_READ, '1, CODE_FOUR);
    drain();

    apply_settings(1'b1, crte_pkg::ROM_SIZE_W'(65536), 32'ha5c3_0f96, 1'b1);
    send_item(ACT_START, {crte_pkg::CMD_READ_ID, 56'h0}, CODE_FOUR);
    repeat (4) send_item(ACT_READ, '0, CODE_NONE);
    send_item(ACT_READ, '0, CODE_NONE);
    // Base zero is lifted and the offset wraps past the end of the page.
    send_item(ACT_START, {crte_pkg::CMD_READ_DATA, 32'h0000_0ffe, 24'h0}, CODE_FOUR);
    repeat (4) send_item(ACT_READ, '0, CODE_NONE);
    send_item(ACT_START, {crte_pkg::CMD_READ_DATA, 32'hffff_ffff, 24'h0}, CODE_NONE);
    send_item(ACT_READ, '0, CODE_NONE);
    send_item(ACT_START, '0, CODE_16K);
    repeat (2) send_item(ACT_READ, '0, CODE_NONE);
    send_item(ACT_START, '1, 3'd5);
    send_item(ACT_READ, '1, CODE_FOUR);
    for (int c = CODE_512; c <= 4; c++)
      send_item(ACT_START, '0, 3'(c));

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: apply_settings(1'b1, crte_pkg::ROM_SIZE_W'(65536), '1, 1'b1);
        1: apply_settings(1'b1, '1, $urandom, 1'b0);
        2: apply_settings(1'b1, crte_pkg::ROM_SIZE_W'(32'h2000_0000), $urandom, 1'b1);
        3: apply_settings(1'b1, crte_pkg::ROM_SIZE_W'(1), '0, 1'b1);
        4: apply_settings(1'b1, '0, $urandom, 1'b0);
        5: apply_settings(1'b0, crte_pkg::ROM_SIZE_W'($urandom), $urandom, 1'b1);
        6: apply_settings(1'b1, crte_pkg::ROM_SIZE_W'($urandom_range(2, 32'h10_0000)),
                          $urandom, 1'($urandom));
        default: apply_settings(1'b1,
                                crte_pkg::ROM_SIZE_W'($urandom_range(1, 32'h2000_0000)),
                                $urandom, 1'b1);
      endcase
      idle_on = (p != 2);
      if (p == 4)
        hold_req = 1'b1;
      random_phase(PHASE_ITEMS);
    end
    drain();
    repeat (4) @(posedge clk);

    if (sb.expected_bytes.size() != 0) begin
      sb.errors += sb.expected_bytes.size();
      $display("ERROR: %0d expected results never arrived", sb.expected_bytes.size());
    end
    $display("Run covered %0d items and %0d checked results over ten register settings,",
             sent, sb.checked);
    $display("with %0d finished transfers, %0d ROM fetches and %0d errors.",
             sb.finished, sb.fetched, sb.errors);
    if (sb.errors == 0)
      $display("card_rom_transfer_engine_tb passed");
    else
      $display("card_rom_transfer_engine_tb failed");
    $finish;
  end

endmodule
